// ----- src/scad_pkg.sv -----
// ----------------------------------------------------------------------------
// scad_pkg
// Shared constants, codes and types of the scroll and change region detector.
// ----------------------------------------------------------------------------
package scad_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 128;

    localparam int PIX_W   = 24;
    localparam int FW_W    = 9;
    localparam int FH_W    = 8;
    localparam int KIND_W  = 2;
    localparam int RX_W    = 8;
    localparam int RW_W    = 9;
    localparam int RH_W    = 8;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 9;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int STORE_DEPTH = 2 ** ADDR_W;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int LVL_W  = $clog2(QDEPTH + 2);

    localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = CIDX_W'(1);

    localparam logic [KIND_W-1:0] KIND_FULL   = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_SCROLL = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_DELTA  = KIND_W'(2);

    typedef struct packed {
        logic [FW_W-1:0] width;
        logic [FH_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] old_pixel;
        logic [COL_W-1:0] col;
        logic             prev_valid;
        logic             last;
    } t_item;

endpackage

// ----- src/scad_ram.sv -----
// ----------------------------------------------------------------------------
// scad_ram
// Generic single-write, single-read RAM with registered read-first output.
// ----------------------------------------------------------------------------
module scad_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/scad_front.sv -----
// ----------------------------------------------------------------------------
// scad_front
// Accepts pixels, tracks the frame position, reads the old pixel and writes
// the new one into the frame store, and hands a tagged item to the queue.
// ----------------------------------------------------------------------------
module scad_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  scad_pkg::t_cfg              i_cfg,
    input  logic                        i_restart,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [scad_pkg::PIX_W-1:0]  i_pixel,
    input  logic [scad_pkg::LVL_W-1:0]  i_q_level,
    output logic                        o_push,
    output scad_pkg::t_item             o_item
);
    import scad_pkg::*;

    logic             r_prev_valid;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pixel;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_pv;
    logic             r_s1_last;
    logic [PIX_W-1:0] ram_rdata;
    logic             accept;
    logic             last_col;
    logic             last_row;
    logic [ADDR_W-1:0] addr;

    assign o_in_stall = (LVL_W'(i_q_level) + LVL_W'(r_s1_valid)) >= LVL_W'(QDEPTH);
    assign accept     = i_in_valid && !o_in_stall;
    assign last_col   = (FW_W'(r_col) + FW_W'(1)) == i_cfg.width;
    assign last_row   = (FH_W'(r_row) + FH_W'(1)) == i_cfg.height;
    assign addr       = {r_row, r_col};

    scad_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (addr),
        .i_wdata (i_pixel),
        .i_re    (accept),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (i_restart) begin
                r_prev_valid <= 1'b0;
                r_col        <= '0;
                r_row        <= '0;
            end else if (accept) begin
                if (!last_col) begin
                    r_col <= r_col + COL_W'(1);
                end else begin
                    r_col <= '0;
                    if (!last_row) begin
                        r_row <= r_row + ROW_W'(1);
                    end else begin
                        r_row        <= '0;
                        r_prev_valid <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel <= i_pixel;
            r_s1_col   <= r_col;
            r_s1_pv    <= r_prev_valid;
            r_s1_last  <= last_col && last_row;
        end
    end

    assign o_push           = r_s1_valid;
    assign o_item.pixel      = r_s1_pixel;
    assign o_item.old_pixel  = ram_rdata;
    assign o_item.col        = r_s1_col;
    assign o_item.prev_valid = r_s1_pv;
    assign o_item.last       = r_s1_last;

endmodule

// ----- src/scad_queue.sv -----
// ----------------------------------------------------------------------------
// scad_queue
// Short FIFO of tagged items between the front and the back.
// ----------------------------------------------------------------------------
module scad_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  scad_pkg::t_item            i_item,
    input  logic                       i_pop,
    output logic                       o_valid,
    output scad_pkg::t_item            o_item,
    output logic [scad_pkg::LVL_W-1:0] o_level
);
    import scad_pkg::*;

    t_item             r_buf [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [LVL_W-1:0]  r_level;
    logic              do_pop;

    assign do_pop = i_pop && (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_level <= r_level + LVL_W'(1);
            end else if (!i_push && do_pop) begin
                r_level <= r_level - LVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_item;
        end
    end

    assign o_valid = r_level != '0;
    assign o_item  = r_buf[r_rptr];
    assign o_level = r_level;

endmodule

// ----- src/scad_back.sv -----
// ----------------------------------------------------------------------------
// scad_back
// Compares each item against the previous frame, accumulates the scroll and
// change flags, and at its last pixel classifies a frame into an update or none.
// ----------------------------------------------------------------------------
module scad_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  scad_pkg::t_cfg               i_cfg,
    input  logic                         i_restart,
    input  logic                         i_q_valid,
    input  scad_pkg::t_item              i_q_item,
    output logic                         o_q_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [scad_pkg::KIND_W-1:0]  o_update_kind,
    output logic [scad_pkg::RX_W-1:0]    o_region_x,
    output logic [scad_pkg::RW_W-1:0]    o_region_width,
    output logic [scad_pkg::RH_W-1:0]    o_region_height
);
    import scad_pkg::*;

    logic             r_shift_match;
    logic             r_any_change;
    logic [COL_W-1:0] r_max_col;
    logic [PIX_W-1:0] r_last_pix;
    logic             r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [RX_W-1:0]  r_rx;
    logic [RW_W-1:0]  r_rw;
    logic [RH_W-1:0]  r_rh;

    logic             out_free;
    logic             pop;
    logic             changed;
    logic             n_shift_match;
    logic             n_any_change;
    logic [COL_W-1:0] n_max_col;
    logic             has_result;
    logic [KIND_W-1:0] n_kind;
    logic [RX_W-1:0]  n_rx;
    logic [RW_W-1:0]  n_rw;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = i_q_valid && (!i_q_item.last || out_free);
    assign o_q_pop  = pop;

    always_comb begin
        changed       = i_q_item.prev_valid && (i_q_item.old_pixel != i_q_item.pixel);
        n_shift_match = r_shift_match;
        if (i_q_item.prev_valid && (i_q_item.col != '0) &&
            (i_q_item.old_pixel != r_last_pix)) begin
            n_shift_match = 1'b0;
        end
        n_any_change = r_any_change || changed;
        n_max_col    = r_max_col;
        if (changed && (!r_any_change || (i_q_item.col > r_max_col))) begin
            n_max_col = i_q_item.col;
        end

        has_result = 1'b1;
        n_kind     = KIND_FULL;
        n_rx       = '0;
        n_rw       = RW_W'(i_cfg.width);
        if (!i_q_item.prev_valid) begin
            n_kind = KIND_FULL;
        end else if (n_shift_match) begin
            n_kind = KIND_SCROLL;
        end else if (n_any_change) begin
            n_kind = KIND_DELTA;
            n_rx   = RX_W'(n_max_col);
            n_rw   = RW_W'(i_cfg.width - FW_W'(n_max_col));
        end else begin
            has_result = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_match <= 1'b1;
            r_any_change  <= 1'b0;
            r_max_col     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_restart || (pop && i_q_item.last)) begin
                r_shift_match <= 1'b1;
                r_any_change  <= 1'b0;
                r_max_col     <= '0;
            end else if (pop) begin
                r_shift_match <= n_shift_match;
                r_any_change  <= n_any_change;
                r_max_col     <= n_max_col;
            end
            if (pop && i_q_item.last && has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_last_pix <= i_q_item.pixel;
        end
        if (pop && i_q_item.last && has_result) begin
            r_kind <= n_kind;
            r_rx   <= n_rx;
            r_rw   <= n_rw;
            r_rh   <= RH_W'(i_cfg.height);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_update_kind   = r_kind;
    assign o_region_x      = r_rx;
    assign o_region_width  = r_rw;
    assign o_region_height = r_rh;

endmodule

// ----- src/scroll_and_change_region_detector.sv -----
// ----------------------------------------------------------------------------
// scroll_and_change_region_detector
// Detects scrolled frames and the changed column region of RGB frames.
//
//   channel  handshake                  payload
//   in       i_in_valid / o_in_stall    i_pixel
//   out      o_out_valid / i_out_stall  o_update_kind, o_region_x,
//                                       o_region_width, o_region_height
//   cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one pixel per cycle unless stalled; the frame store port does one read and
// one write per item; any result is registered when a frame's last pixel is popped.
// synchronous reset clears control state; the frame store is not cleared.
// a stalled output holds only the back part; the front keeps accepting until
// the four-entry queue fills.
// ----------------------------------------------------------------------------
module scroll_and_change_region_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [scad_pkg::PIX_W-1:0]    i_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [scad_pkg::KIND_W-1:0]   o_update_kind,
    output logic [scad_pkg::RX_W-1:0]     o_region_x,
    output logic [scad_pkg::RW_W-1:0]     o_region_width,
    output logic [scad_pkg::RH_W-1:0]     o_region_height,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [scad_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [scad_pkg::CDATA_W-1:0]  i_cfg_data
);
    import scad_pkg::*;

    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic             cfg_wr;
    logic             restart;
    t_cfg             cfg;
    logic             push;
    t_item            push_item;
    logic             q_valid;
    t_item            q_item;
    logic             q_pop;
    logic [LVL_W-1:0] q_level;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_wr && ((i_cfg_index == REG_FRAME_WIDTH) ||
                                    (i_cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(MAX_WIDTH);
            r_frame_height <= FH_W'(MAX_HEIGHT);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH: begin
                    r_frame_width <= FW_W'(i_cfg_data);
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= FH_W'(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_frame_width == '0) begin
            cfg.width = FW_W'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            cfg.width = FW_W'(MAX_WIDTH);
        end else begin
            cfg.width = r_frame_width;
        end
        if (r_frame_height == '0) begin
            cfg.height = FH_W'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            cfg.height = FH_W'(MAX_HEIGHT);
        end else begin
            cfg.height = r_frame_height;
        end
    end

    scad_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_restart  (restart),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_pixel    (i_pixel),
        .i_q_level  (q_level),
        .o_push     (push),
        .o_item     (push_item)
    );

    scad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_level (q_level)
    );

    scad_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_restart       (restart),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_update_kind   (o_update_kind),
        .o_region_x      (o_region_x),
        .o_region_width  (o_region_width),
        .o_region_height (o_region_height)
    );

endmodule

// ----- test/tb_scroll_and_change_region_detector.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scroll_and_change_region_detector
// Streams frames of RGB pixels through the detector under random idle and
// stall on both channels. The frames are fresh, repeated, shifted one column,
// touched in a few columns, or flat. A local tracker of the previous frame
// predicts the update reported at each frame end, and every reported update is
// compared field by field. Frame sizes are rewritten between phases: zero and
// oversize values, full width and full height, and many small frames.
// ----------------------------------------------------------------------------
module tb_scroll_and_change_region_detector;
    import scad_pkg::*;

    localparam logic [CIDX_W-1:0] REG_SPARE_A = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] REG_SPARE_B = CIDX_W'(3);

    localparam int STYLE_FRESH = 0;
    localparam int STYLE_SAME  = 1;
    localparam int STYLE_SHIFT = 2;
    localparam int STYLE_TOUCH = 3;
    localparam int STYLE_FLAT  = 4;

    localparam int WHOLE_FRAME   = 1 << 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEM_TARGET   = 1700;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [RX_W-1:0]   x;
        logic [RW_W-1:0]   width;
        logic [RH_W-1:0]   height;
    } t_region;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [PIX_W-1:0]     i_pixel = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [KIND_W-1:0]    o_update_kind;
    logic [RX_W-1:0]      o_region_x;
    logic [RW_W-1:0]      o_region_width;
    logic [RH_W-1:0]      o_region_height;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CIDX_W-1:0]    i_cfg_index = '0;
    logic [CDATA_W-1:0]   i_cfg_data = '0;

    scroll_and_change_region_detector uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pixel         (i_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_update_kind   (o_update_kind),
        .o_region_x      (o_region_x),
        .o_region_width  (o_region_width),
        .o_region_height (o_region_height),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // frame tracker state
    logic [FW_W-1:0]  width_reg = FW_W'(MAX_WIDTH);
    logic [FH_W-1:0]  height_reg = FH_W'(MAX_HEIGHT);
    logic             have_prev = 1'b0;
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;
    logic             scroll_ok = 1'b1;
    logic             changed = 1'b0;
    int unsigned      right_col = 0;
    logic [PIX_W-1:0] seen_frame [0:STORE_DEPTH-1];

    logic [PIX_W-1:0] sent_frame [0:STORE_DEPTH-1];
    logic [PIX_W-1:0] pixel_queue [$];
    t_region          pending_updates [$];

    int gap_pct = 31;
    int stall_pct = 31;
    int hold_asked = 0;
    int hold_given = 0;
    int hold_left = 0;
    int errors = 0;
    int pixels_queued = 0;
    int pixels_taken = 0;
    int updates_checked = 0;
    int reg_writes = 0;
    int n_full = 0;
    int n_scroll = 0;
    int n_delta = 0;
    int n_quiet = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function void restart_frame();
        col_pos = 0;
        row_pos = 0;
        scroll_ok = 1'b1;
        changed = 1'b0;
        right_col = 0;
    endfunction

    function void apply_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        if (idx == REG_FRAME_WIDTH) begin
            width_reg = data[FW_W-1:0];
        end else if (idx == REG_FRAME_HEIGHT) begin
            height_reg = data[FH_W-1:0];
        end else begin
            return;
        end
        have_prev = 1'b0;
        restart_frame();
    endfunction

    function void track_pixel(input logic [PIX_W-1:0] pix);
        int unsigned w, h, x, y, at;
        t_region u;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        x = col_pos;
        y = row_pos;
        at = y * MAX_WIDTH + x;
        if (have_prev) begin
            if (x + 1 < w && seen_frame[at + 1] != pix) scroll_ok = 1'b0;
            if (seen_frame[at] != pix) begin
                if (!changed || x > right_col) right_col = x;
                changed = 1'b1;
            end
        end
        seen_frame[at] = pix;
        x++;
        if (x < w) begin
            col_pos = x;
            return;
        end
        col_pos = 0;
        y++;
        if (y < h) begin
            row_pos = y;
            return;
        end
        u.x = '0;
        u.width = RW_W'(w);
        u.height = RH_W'(h);
        if (!have_prev) begin
            u.kind = KIND_FULL;
            n_full++;
            pending_updates.push_back(u);
        end else if (scroll_ok) begin
            u.kind = KIND_SCROLL;
            n_scroll++;
            pending_updates.push_back(u);
        end else if (changed) begin
            u.kind = KIND_DELTA;
            u.x = RX_W'(right_col);
            u.width = RW_W'(w - right_col);
            n_delta++;
            pending_updates.push_back(u);
        end else begin
            n_quiet++;
        end
        have_prev = 1'b1;
        restart_frame();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        if (errors <= 40)
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // pixel driver
    always @(posedge i_clk) begin : drive
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                track_pixel(i_pixel);
                void'(pixel_queue.pop_front());
                pixels_taken++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_pixel <= pixel_queue[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // update monitor
    always @(posedge i_clk) begin : watch
        t_region want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_updates.size() == 0) begin
                report_mismatch("update kind with none pending", 0, o_update_kind);
            end else begin
                want = pending_updates.pop_front();
                updates_checked++;
                if (o_update_kind !== want.kind)
                    report_mismatch("update_kind", want.kind, o_update_kind);
                if (o_region_x !== want.x)
                    report_mismatch("region_x", want.x, o_region_x);
                if (o_region_width !== want.width)
                    report_mismatch("region_width", want.width, o_region_width);
                if (o_region_height !== want.height)
                    report_mismatch("region_height", want.height, o_region_height);
            end
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_given != hold_asked) begin
            hold_given++;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_reg(idx, data);
        reg_writes++;
    endtask

    task automatic queue_pixel(input logic [PIX_W-1:0] pix);
        pixel_queue.push_back(pix);
        pixels_queued++;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: return PIX_W'($urandom_range(2));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic int pick_style();
        int r;
        r = $urandom_range(99);
        if (r < 15) return STYLE_FRESH;
        if (r < 30) return STYLE_SAME;
        if (r < 55) return STYLE_SHIFT;
        if (r < 88) return STYLE_TOUCH;
        return STYLE_FLAT;
    endfunction

    task automatic send_frame(input int style, input int count, input int touch_col);
        int unsigned w, h, x, y, at, c, key_row;
        int n;
        logic [PIX_W-1:0] base, pix;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        base = pick_pixel();
        key_row = $urandom_range(h - 1);
        n = 0;
        if (touch_col >= 0) begin
            c = touch_col;
        end else begin
            case ($urandom_range(3))
                0: c = w - 1;
                1: c = 0;
                default: c = $urandom_range(w - 1);
            endcase
        end
        for (y = 0; y < h; y++) begin
            for (x = 0; x < w; x++) begin
                if (n == count) return;
                at = y * MAX_WIDTH + x;
                case (style)
                    STYLE_SAME: pix = sent_frame[at];
                    STYLE_SHIFT: pix = (x + 1 < w) ? sent_frame[at + 1] : pick_pixel();
                    STYLE_TOUCH: begin
                        pix = sent_frame[at];
                        if (x == c && (y == key_row || $urandom_range(1) == 1))
                            pix = pix ^ (PIX_W'(1) << $urandom_range(PIX_W - 1));
                        else if (x < c && $urandom_range(9) == 0)
                            pix = pick_pixel();
                    end
                    STYLE_FLAT: pix = base;
                    default: pix = pick_pixel();
                endcase
                sent_frame[at] = pix;
                queue_pixel(pix);
                n++;
            end
        end
    endtask

    task automatic drain();
        while (pixel_queue.size() != 0 || i_in_valid || pending_updates.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int area, frames, round;
        for (int i = 0; i < STORE_DEPTH; i++) sent_frame[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // one-pixel frames from zero-sized registers
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);
        queue_pixel(24'h000000);
        queue_pixel(24'h000000);
        queue_pixel(24'hFFFFFF);
        queue_pixel(24'hFFFFFF);
        settle();

        // two-column frames: full, unchanged, shift, deltas, uniform
        write_reg(REG_FRAME_WIDTH, CDATA_W'(2));
        write_reg(REG_FRAME_HEIGHT, CDATA_W'(1));
        queue_pixel(24'd1); queue_pixel(24'd2);
        queue_pixel(24'd1); queue_pixel(24'd2);
        queue_pixel(24'd2); queue_pixel(24'd9);
        queue_pixel(24'd2); queue_pixel(24'd5);
        queue_pixel(24'd7); queue_pixel(24'd5);
        queue_pixel(24'd3); queue_pixel(24'd3);
        settle();
        // unused indexes must leave the stored frame valid
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, CDATA_W'(9'h0AA));
        queue_pixel(24'd3); queue_pixel(24'd3);
        settle();

        // full width, one row
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, CDATA_W'(1));
        send_frame(STYLE_FRESH, WHOLE_FRAME, -1);
        send_frame(STYLE_TOUCH, WHOLE_FRAME, MAX_WIDTH - 1);
        send_frame(STYLE_SHIFT, WHOLE_FRAME, -1);
        settle();

        // one column, full height
        write_reg(REG_FRAME_WIDTH, CDATA_W'(1));
        write_reg(REG_FRAME_HEIGHT, '1);
        send_frame(STYLE_FRESH, WHOLE_FRAME, -1);
        send_frame(STYLE_SAME, WHOLE_FRAME, -1);
        send_frame(STYLE_TOUCH, WHOLE_FRAME, -1);
        settle();

        // broken frame at maximum width, cut short by a register write
        write_reg(REG_FRAME_WIDTH, CDATA_W'(MAX_WIDTH));
        write_reg(REG_FRAME_HEIGHT, '0);
        send_frame(STYLE_FRESH, 60, -1);
        settle();

        // backpressure: one-pixel frames while the output is held off
        write_reg(REG_FRAME_WIDTH, CDATA_W'(1));
        write_reg(REG_FRAME_HEIGHT, CDATA_W'(1));
        gap_pct = 0;
        hold_asked++;
        repeat (40) queue_pixel(pick_pixel());
        drain();
        gap_pct = 31;

        round = 0;
        while (pixels_queued < ITEM_TARGET) begin
            settle();
            gap_pct = (round == 1 || round == 2) ? 0 : 31;
            stall_pct = gap_pct;
            case ($urandom_range(5))
                0: write_reg(REG_FRAME_WIDTH, CDATA_W'($urandom_range(8, 1)));
                1: write_reg(REG_FRAME_HEIGHT, CDATA_W'($urandom_range(4, 1)));
                default: begin
                    if ($urandom_range(3) == 0) write_reg(REG_SPARE_A, CDATA_W'($urandom));
                    write_reg(REG_FRAME_WIDTH, ($urandom_range(4) == 0) ?
                              CDATA_W'($urandom_range(24, 9)) : CDATA_W'($urandom_range(8, 1)));
                    write_reg(REG_FRAME_HEIGHT, ($urandom_range(4) == 0) ?
                              CDATA_W'($urandom_range(10, 5)) : CDATA_W'($urandom_range(4, 1)));
                end
            endcase
            area = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
            frames = (gap_pct == 0) ? 10 : $urandom_range(7, 3);
            for (int f = 0; f < frames; f++) begin
                send_frame(pick_style(), WHOLE_FRAME, -1);
                if ($urandom_range(7) == 0) drain();
            end
            if (area > 1 && $urandom_range(4) == 0)
                send_frame(pick_style(), $urandom_range(area - 1, 1), -1);
            round++;
        end
        gap_pct = 31;
        stall_pct = 31;

        settle();
        $display("pixels sent %0d over %0d register writes, updates checked %0d",
                 pixels_taken, reg_writes, updates_checked);
        $display("frames: %0d full, %0d scrolled, %0d delta, %0d unchanged",
                 n_full, n_scroll, n_delta, n_quiet);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
src/scad_pkg.sv
src/scad_ram.sv
src/scad_front.sv
src/scad_queue.sv
src/scad_back.sv
src/scroll_and_change_region_detector.sv
test/tb_scroll_and_change_region_detector.sv
